FILE: sv/irpfd_pkg.sv
`timescale 1ns / 1ps

package irpfd_pkg;

	// Frame geometry and output scaling
	localparam int FRAME_BITS = 32;
	localparam int CNT_W      = $clog2(FRAME_BITS + 1);
	localparam int POS_W      = $clog2(FRAME_BITS);
	localparam int DUTY_STEP  = 125;
	localparam int DUTY_W     = 10;
	localparam int LEVEL_W    = 4;
	localparam int TIME_W     = 16;

	localparam logic [LEVEL_W-1:0] MAX_LEVEL   = LEVEL_W'(8);
	localparam logic [LEVEL_W-1:0] RESET_LEVEL = LEVEL_W'(4);

	// Remote command codes
	localparam logic [31:0] CODE_LED_ON  = 32'h00FF_A857;
	localparam logic [31:0] CODE_LED_OFF = 32'h00FF_E01F;
	localparam logic [31:0] CODE_UP      = 32'h00FF_E21D;
	localparam logic [31:0] CODE_DOWN    = 32'h00FF_A25D;

	// Decoder phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LEAD = 2'd1;
	localparam logic [1:0] PH_BITS = 2'd2;

	// Register map
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_LOW_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_LOW_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_HIGH_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_HIGH_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX       = 3'd7;

	typedef struct packed {
		logic [TIME_W-1:0] capture_time;
		logic              edge_level;
	} in_item_t;

	typedef struct packed {
		logic               frame_done;
		logic [31:0]        command_code;
		logic               led1_on;
		logic [LEVEL_W-1:0] brightness_level;
		logic [DUTY_W-1:0]  pwm_duty;
		logic [1:0]         decoder_phase;
	} out_item_t;

	// Pulse width windows, all bounds exclusive
	typedef struct packed {
		logic [TIME_W-1:0] lead_low_min;
		logic [TIME_W-1:0] lead_low_max;
		logic [TIME_W-1:0] lead_high_min;
		logic [TIME_W-1:0] lead_high_max;
		logic [TIME_W-1:0] zero_min;
		logic [TIME_W-1:0] zero_max;
		logic [TIME_W-1:0] one_min;
		logic [TIME_W-1:0] one_max;
	} win_t;

	function automatic logic in_window(input logic [TIME_W-1:0] w,
		input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
		return (w > lo) && (w < hi);
	endfunction

endpackage

FILE: sv/irpfd_cfg_regs.sv
`timescale 1ns / 1ps

module irpfd_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [irpfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [irpfd_pkg::TIME_W-1:0]       cfg_data,
	output irpfd_pkg::win_t                    win
);

	irpfd_pkg::win_t win_q;

	assign cfg_ready = 1'b1;
	assign win       = win_q;

	// Window registers, reset to the standard timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.lead_low_min  <= 16'd8000;
			win_q.lead_low_max  <= 16'd10000;
			win_q.lead_high_min <= 16'd3000;
			win_q.lead_high_max <= 16'd6000;
			win_q.zero_min      <= 16'd400;
			win_q.zero_max      <= 16'd800;
			win_q.one_min       <= 16'd1400;
			win_q.one_max       <= 16'd1900;
		end else if (cfg_valid) begin
			case (cfg_index)
				irpfd_pkg::REG_LEAD_LOW_MIN:  win_q.lead_low_min  <= cfg_data;
				irpfd_pkg::REG_LEAD_LOW_MAX:  win_q.lead_low_max  <= cfg_data;
				irpfd_pkg::REG_LEAD_HIGH_MIN: win_q.lead_high_min <= cfg_data;
				irpfd_pkg::REG_LEAD_HIGH_MAX: win_q.lead_high_max <= cfg_data;
				irpfd_pkg::REG_ZERO_MIN:      win_q.zero_min      <= cfg_data;
				irpfd_pkg::REG_ZERO_MAX:      win_q.zero_max      <= cfg_data;
				irpfd_pkg::REG_ONE_MIN:       win_q.one_min       <= cfg_data;
				irpfd_pkg::REG_ONE_MAX:       win_q.one_max       <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/irpfd_core.sv
`timescale 1ns / 1ps

module irpfd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  irpfd_pkg::in_item_t   in_data,
	input  irpfd_pkg::win_t       win,
	input  logic                  res_take,
	output logic                  res_load,
	output irpfd_pkg::out_item_t  res_item
);

	// Input register
	logic                 valid_s1;
	irpfd_pkg::in_item_t  item_s1;

	// Decoder state
	logic [irpfd_pkg::TIME_W-1:0]  prev_cap_q;
	logic [1:0]                    phase_q;
	logic [irpfd_pkg::CNT_W-1:0]   bit_cnt_q;
	logic [31:0]                   shift_q;
	logic                          led_q;
	logic [irpfd_pkg::LEVEL_W-1:0] level_q;

	logic [1:0]                    phase_d;
	logic [irpfd_pkg::CNT_W-1:0]   bit_cnt_d;
	logic [31:0]                   shift_d;
	logic                          led_d;
	logic [irpfd_pkg::LEVEL_W-1:0] level_d;
	logic                          done;
	logic [irpfd_pkg::TIME_W-1:0]  width;
	logic [irpfd_pkg::POS_W-1:0]   pos;
	logic                          is_zero;
	logic                          is_one;
	logic                          advance;

	assign advance  = valid_s1 && res_take;
	assign res_load = advance;
	assign in_stall = valid_s1 && !res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Width since the previous edge, wrapping
	assign width   = item_s1.capture_time - prev_cap_q;
	assign pos     = irpfd_pkg::POS_W'(irpfd_pkg::FRAME_BITS - 1) - bit_cnt_q[irpfd_pkg::POS_W-1:0];
	assign is_zero = irpfd_pkg::in_window(width, win.zero_min, win.zero_max);
	assign is_one  = irpfd_pkg::in_window(width, win.one_min, win.one_max);

	// Next state and frame dispatch
	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		led_d     = led_q;
		level_d   = level_q;
		done      = 1'b0;
		case (phase_q)
			irpfd_pkg::PH_LEAD: begin
				if (!item_s1.edge_level) begin
					if (irpfd_pkg::in_window(width, win.lead_high_min, win.lead_high_max)) begin
						phase_d   = irpfd_pkg::PH_BITS;
						shift_d   = '0;
						bit_cnt_d = '0;
					end else begin
						phase_d = irpfd_pkg::PH_IDLE;
					end
				end
			end
			irpfd_pkg::PH_BITS: begin
				if (!item_s1.edge_level) begin
					if (is_zero || is_one) begin
						shift_d[pos] = !is_zero;
						bit_cnt_d    = bit_cnt_q + 1'b1;
						if (bit_cnt_d == irpfd_pkg::CNT_W'(irpfd_pkg::FRAME_BITS)) begin
							phase_d = irpfd_pkg::PH_IDLE;
							done    = 1'b1;
							if (shift_d == irpfd_pkg::CODE_LED_ON) begin
								led_d = 1'b1;
							end else if (shift_d == irpfd_pkg::CODE_LED_OFF) begin
								led_d = 1'b0;
							end else if (shift_d == irpfd_pkg::CODE_UP) begin
								if (level_q < irpfd_pkg::MAX_LEVEL) level_d = level_q + 1'b1;
							end else if (shift_d == irpfd_pkg::CODE_DOWN) begin
								if (level_q != '0) level_d = level_q - 1'b1;
							end
						end
					end else begin
						phase_d = irpfd_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = irpfd_pkg::PH_IDLE;
				if (item_s1.edge_level &&
					irpfd_pkg::in_window(width, win.lead_low_min, win.lead_low_max)) begin
					phase_d = irpfd_pkg::PH_LEAD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cap_q <= '0;
			phase_q    <= irpfd_pkg::PH_IDLE;
			bit_cnt_q  <= '0;
			shift_q    <= '0;
			led_q      <= 1'b0;
			level_q    <= irpfd_pkg::RESET_LEVEL;
		end else if (advance) begin
			prev_cap_q <= item_s1.capture_time;
			phase_q    <= phase_d;
			bit_cnt_q  <= bit_cnt_d;
			shift_q    <= shift_d;
			led_q      <= led_d;
			level_q    <= level_d;
		end
	end

	// Result word
	always_comb begin
		res_item.frame_done       = done;
		res_item.command_code     = done ? shift_d : 32'd0;
		res_item.led1_on          = led_d;
		res_item.brightness_level = level_d;
		res_item.pwm_duty         = irpfd_pkg::DUTY_W'(level_d * irpfd_pkg::DUTY_STEP);
		res_item.decoder_phase    = phase_d;
	end

endmodule

FILE: sv/irpfd_out_reg.sv
`timescale 1ns / 1ps

module irpfd_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_load,
	input  irpfd_pkg::out_item_t  res_item,
	output logic                  res_take,
	output logic                  out_valid,
	input  logic                  out_stall,
	output irpfd_pkg::out_item_t  out_data
);

	logic                 valid_q;
	irpfd_pkg::out_item_t data_q;

	// Free when empty or when the held word leaves this cycle
	assign res_take  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_take) begin
			valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			data_q <= res_item;
		end
	end

endmodule

FILE: sv/ir_pulse_frame_decoder_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// in        sink       in_valid / in_stall  in_data   (capture_time, edge_level)
// out       source     out_valid / out_stall out_data (frame_done .. decoder_phase)
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data (window bounds)
//
// One edge word per cycle while out_stall is low; an accepted word passes the input
// register, then the result register, before out_valid rises.
// The decode between the two registers is a 16-bit subtract, window compares and
// a 32-bit code match.
// arst_n resets the decoder (level 4) and valid flags and loads the default windows.
// An output stall backs up into the input register; one more word is taken while
// a result waits.

module ir_pulse_frame_decoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  irpfd_pkg::in_item_t             in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output irpfd_pkg::out_item_t            out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [irpfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irpfd_pkg::TIME_W-1:0]    cfg_data
);

	irpfd_pkg::win_t      win;
	irpfd_pkg::out_item_t res_item;
	logic                 res_take;
	logic                 res_load;

	irpfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.win       (win)
	);

	irpfd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.win      (win),
		.res_take (res_take),
		.res_load (res_load),
		.res_item (res_item)
	);

	irpfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res_item  (res_item),
		.res_take  (res_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: sv/irpfd_checker.sv
`timescale 1ns / 1ps

module irpfd_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  irpfd_pkg::out_item_t  out_data
);

	// A held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed under stall");

	// A finished frame always returns the decoder to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> out_data.decoder_phase == irpfd_pkg::PH_IDLE)
		else $error("frame done outside idle");

	// Duty follows the brightness level, which stays in range
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.brightness_level <= irpfd_pkg::MAX_LEVEL &&
		out_data.pwm_duty == irpfd_pkg::DUTY_W'(out_data.brightness_level *
			irpfd_pkg::DUTY_STEP))
		else $error("duty or level out of step");

	// Input is only held back while the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid && out_stall)
		else $error("input stalled with a free output");

endmodule

bind ir_pulse_frame_decoder_top irpfd_checker u_irpfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
